[rtl/core/gbm_pkg.sv]
// ----------------------------------------------------------------------------
// gbm_pkg: shared definitions for the grid border marking block
// Sizes, cell codes, register indexes and the result item types.
// ----------------------------------------------------------------------------
`default_nettype none

package gbm_pkg;

   localparam int MAX_COLS   = 1024;
   localparam int MAX_ROWS   = 1024;
   localparam int MAX_RADIUS = 4;

   localparam int CFG_W     = 11;
   localparam int RAD_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int VAL_W     = 2;

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);

   localparam int STORE_DEPTH = MAX_RADIUS * MAX_COLS + MAX_RADIUS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int DEPTH_W     = CFG_W + RAD_W;

   localparam int RUN_CAP = 2 * MAX_RADIUS + 1;
   localparam int RUN_W   = $clog2(RUN_CAP + 1);
   localparam int WIN_W   = RUN_CAP;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int REQ_DATA_W = ((VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ROW_W + COL_W + VAL_W + 7) / 8) * 8;

   localparam logic [VAL_W-1:0] CELL_OPEN       = 2'd0;
   localparam logic [VAL_W-1:0] CELL_OBSTRUCTED = 2'd1;
   localparam logic [VAL_W-1:0] CELL_UNKNOWN    = 2'd2;
   localparam logic [VAL_W-1:0] CELL_BORDER     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_RADIUS = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] value;
   } result_type;

   typedef struct packed {
      result_type first;
      result_type second;
      logic       pair;
   } pair_type;

endpackage

`default_nettype wire

[rtl/core/gbm_value_line.sv]
// ----------------------------------------------------------------------------
// gbm_value_line: circular delay line of cell values
// Single-port synchronous memory; read returns the old entry while the new
// value is written at the same address.
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_value_line (
   input  logic                          clock,
   input  logic                          en,
   input  logic [gbm_pkg::STORE_AW-1:0]  addr,
   input  logic [gbm_pkg::VAL_W-1:0]     wdata,
   output logic [gbm_pkg::VAL_W-1:0]     rdata
);
   import gbm_pkg::*;

   logic [VAL_W-1:0] mem [STORE_DEPTH];
   logic [VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff   <= mem[addr];
         mem[addr]  <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/core/gbm_run_store.sv]
// ----------------------------------------------------------------------------
// gbm_run_store: per-column clear-run counts
// Synchronous memory with one read and one write port; forwards the value
// written at the same edge as a read of the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_run_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [gbm_pkg::COL_W-1:0]   rd_addr,
   input  logic                        wr_en,
   input  logic [gbm_pkg::COL_W-1:0]   wr_addr,
   input  logic [gbm_pkg::RUN_W-1:0]   wr_data,
   output logic [gbm_pkg::RUN_W-1:0]   rd_data
);
   import gbm_pkg::*;

   logic [RUN_W-1:0] mem [MAX_COLS];
   logic [RUN_W-1:0] rdata_ff;
   logic [RUN_W-1:0] fwd_data_ff;
   logic             fwd_ff;
   logic             fwd_in;

   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rdata_ff;

endmodule

`default_nettype wire

[rtl/core/gbm_out_queue.sv]
// ----------------------------------------------------------------------------
// gbm_out_queue: result queue
// Holds up to QDEPTH groups of one or two results and hands them out one
// item at a time, marking the last item of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_out_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_en,
   input  gbm_pkg::pair_type           push_data,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output gbm_pkg::result_type         rsp_result,
   output logic                        rsp_last,
   output logic [gbm_pkg::QCNT_W-1:0]  count
);
   import gbm_pkg::*;

   pair_type          entries_ff [QDEPTH];
   logic [QAW-1:0]    head_ff, head_in;
   logic [QAW-1:0]    tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              half_ff, half_in;
   pair_type          head;
   logic              pop_item;
   logic              pop_entry;

   assign head       = entries_ff[head_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_result = half_ff ? head.second : head.first;
   assign rsp_last   = !head.pair || half_ff;
   assign count      = count_ff;

   assign pop_item  = rsp_tvalid && rsp_tready;
   assign pop_entry = pop_item && rsp_last;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      half_in  = half_ff;
      if (push_en) begin
         tail_in = tail_ff + QAW'(1);
      end
      if (pop_entry) begin
         head_in = head_ff + QAW'(1);
         half_in = 1'b0;
      end else if (pop_item) begin
         half_in = 1'b1;
      end
      count_in = count_ff + QCNT_W'(push_en) - QCNT_W'(pop_entry);
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entries_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         half_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         half_ff  <= half_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/grid_border_marking.sv]
// ----------------------------------------------------------------------------
// grid_border_marking: border marking of free space in an occupancy grid
// Cells enter in raster order on the req_ side, one 2-bit class per item.
// Each item releases zero, one or two results on the rsp_ side, tagged with
// row and column; rsp_tlast marks the final result released by an item.
// An open cell becomes a border cell when its window of the configured
// radius holds an obstructed or unknown cell or leaves the grid.
// Edge cells come out for the arriving item; an interior cell comes out
// when the bottom-right cell of its window arrives, ahead of that edge cell.
// Throughput: one item per cycle while req_tready is high, set by the one
// read and one write per cycle of the value delay line and of the column
// run memory; the two results of an item leave rsp_ one at a time. Each
// result passes the s1_ registers and the result queue before rsp_.
// When rsp_tready is held low, results collect in a four-group queue and
// req_tready drops once the queue and the compute stage can take no more.
// Reset is synchronous: it empties the pipeline and queue, starts the frame
// at row 0 column 0 and loads 1024 columns, 1024 rows and radius 1.
// csr_ writes take effect at once and restart the frame; write only while
// the block is idle. Memory contents need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_border_marking (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cell_value
   input  logic [gbm_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_row, cell_col, new_value
   output logic [gbm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [gbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gbm_pkg::CFG_W-1:0]         csr_wdata
);
   import gbm_pkg::*;

   logic [CFG_W-1:0]    cols_ff, cols_in;
   logic [CFG_W-1:0]    rows_ff, rows_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic                restart;

   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [STORE_AW-1:0] ptr_ff, ptr_in;
   logic [WIN_W-1:0]    win_ff, win_in;

   logic                s1_valid_ff;
   logic [VAL_W-1:0]    s1_value_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_first_row_ff;
   logic                s1_interior_ff;
   logic                s1_edge_ff;
   logic                s1_bypass_ff;

   logic                accept;
   logic [VAL_W-1:0]    value0;
   logic [CFG_W-1:0]    row_x, col_x, rad_x, two_rad_x;
   logic                interior0, edge0, last_col0, last_row0;
   logic [DEPTH_W-1:0]  depth, ptr_next_x;

   logic [VAL_W-1:0]    vl_rdata;
   logic [RUN_W-1:0]    run_old, run1, span;
   logic                clear1, flag1, win_clear;
   logic [WIN_W-1:0]    win_next, span_mask;
   logic [VAL_W-1:0]    delayed;
   result_type          int_res, edge_res, rsp_result;
   pair_type            push_data;
   logic                push_en;
   logic                rsp_last;
   logic [QCNT_W-1:0]   q_count;
   logic [QCNT_W:0]     q_load;

   // configuration
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      rad_in  = rad_ff;
      restart = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: begin
               restart = 1'b1;
               if (csr_wdata == '0) cols_in = CFG_W'(1);
               else if (csr_wdata > CFG_W'(MAX_COLS)) cols_in = CFG_W'(MAX_COLS);
               else cols_in = csr_wdata;
            end
            CSR_GRID_ROWS: begin
               restart = 1'b1;
               if (csr_wdata == '0) rows_in = CFG_W'(1);
               else if (csr_wdata > CFG_W'(MAX_ROWS)) rows_in = CFG_W'(MAX_ROWS);
               else rows_in = csr_wdata;
            end
            CSR_BORDER_RADIUS: begin
               restart = 1'b1;
               if (csr_wdata[RAD_W-1:0] > RAD_W'(MAX_RADIUS)) rad_in = RAD_W'(MAX_RADIUS);
               else rad_in = csr_wdata[RAD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // accept stage
   assign accept    = req_tvalid && req_tready;
   assign value0    = req_tdata[VAL_W-1:0];
   assign row_x     = CFG_W'(row_ff);
   assign col_x     = CFG_W'(col_ff);
   assign rad_x     = CFG_W'(rad_ff);
   assign two_rad_x = CFG_W'({rad_ff, 1'b0});

   assign interior0 = (row_x >= two_rad_x) && (col_x >= two_rad_x);
   assign edge0     = (row_x < rad_x) || (col_x < rad_x) ||
                      (row_x + rad_x >= rows_ff) || (col_x + rad_x >= cols_ff);
   assign last_col0 = (col_x + CFG_W'(1) >= cols_ff);
   assign last_row0 = (row_x + CFG_W'(1) >= rows_ff);

   assign depth      = DEPTH_W'(rad_ff) * DEPTH_W'(cols_ff) + DEPTH_W'(rad_ff);
   assign ptr_next_x = DEPTH_W'(ptr_ff) + DEPTH_W'(1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      ptr_in = ptr_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
         ptr_in = '0;
      end else if (accept) begin
         if (last_col0) begin
            col_in = '0;
            row_in = last_row0 ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
         if ((last_col0 && last_row0) || (ptr_next_x >= depth)) ptr_in = '0;
         else ptr_in = ptr_next_x[STORE_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= CFG_W'(MAX_COLS);
         rows_ff     <= CFG_W'(MAX_ROWS);
         rad_ff      <= RAD_W'(1);
         row_ff      <= '0;
         col_ff      <= '0;
         ptr_ff      <= '0;
         win_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cols_ff     <= cols_in;
         rows_ff     <= rows_in;
         rad_ff      <= rad_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         ptr_ff      <= ptr_in;
         win_ff      <= win_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff     <= value0;
         s1_row_ff       <= row_ff;
         s1_col_ff       <= col_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_interior_ff  <= interior0;
         s1_edge_ff      <= edge0;
         s1_bypass_ff    <= (rad_ff == '0);
      end
   end

   gbm_value_line u_value_line (
      .clock (clock),
      .en    (accept && (rad_ff != '0)),
      .addr  (ptr_ff),
      .wdata (value0),
      .rdata (vl_rdata)
   );

   gbm_run_store u_run_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (run1),
      .rd_data (run_old)
   );

   // decide stage
   assign clear1 = (s1_value_ff == CELL_OPEN) || (s1_value_ff == CELL_BORDER);

   always_comb begin
      if (!clear1) run1 = '0;
      else if (s1_first_row_ff) run1 = RUN_W'(1);
      else if (run_old >= RUN_W'(RUN_CAP)) run1 = RUN_W'(RUN_CAP);
      else run1 = run_old + RUN_W'(1);
   end

   assign span      = RUN_W'({rad_ff, 1'b0}) + RUN_W'(1);
   assign flag1     = (run1 >= span);
   assign win_next  = (s1_col_ff == '0) ? WIN_W'(flag1) : {win_ff[WIN_W-2:0], flag1};
   assign span_mask = ~({WIN_W{1'b1}} << span);
   assign win_clear = ((win_next & span_mask) == span_mask);

   always_comb begin
      win_in = win_ff;
      if (restart) win_in = '0;
      else if (s1_valid_ff) win_in = win_next;
   end

   assign delayed = s1_bypass_ff ? s1_value_ff : vl_rdata;

   always_comb begin
      int_res.row    = s1_row_ff - ROW_W'(rad_ff);
      int_res.col    = s1_col_ff - COL_W'(rad_ff);
      int_res.value  = ((delayed == CELL_OPEN) && !win_clear) ? CELL_BORDER : delayed;
      edge_res.row   = s1_row_ff;
      edge_res.col   = s1_col_ff;
      edge_res.value = (s1_value_ff == CELL_OPEN) ? CELL_BORDER : s1_value_ff;
      push_data.first  = s1_interior_ff ? int_res : edge_res;
      push_data.second = edge_res;
      push_data.pair   = s1_interior_ff && s1_edge_ff;
   end

   assign push_en = s1_valid_ff && (s1_interior_ff || s1_edge_ff);

   gbm_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_data  (push_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_last),
      .count      (q_count)
   );

   assign q_load     = {1'b0, q_count} + (QCNT_W + 1)'(s1_valid_ff);
   assign req_tready = (q_load < (QCNT_W + 1)'(QDEPTH));

   assign rsp_tdata = RSP_DATA_W'({rsp_result.value, rsp_result.col, rsp_result.row});
   assign rsp_tlast = rsp_last;

endmodule

`default_nettype wire

[rtl/core/gbm_checker.sv]
// ----------------------------------------------------------------------------
// gbm_checker: port-level checks for grid_border_marking
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [gbm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              rsp_tlast
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty and ready after reset");

   a_backpressure_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no result pending");

endmodule

bind grid_border_marking gbm_checker u_gbm_checker (.*);

`default_nettype wire
